/* rtl/ipv4ffe_pkg.sv */
// Shared types, constants and field layouts for the IPv4 flow feature extractor.
package ipv4ffe_pkg;

    // Frame length limit; bytes past it are counted out of the capture.
    localparam int MaxFrameBytes = 4096;
    localparam int LenW          = $clog2(MaxFrameBytes + 1);
    localparam int PayW          = 13;

    // Frame layout constants.
    localparam int MinFrameBytes = 34;
    localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
    localparam logic [7:0]  ProtoTcp      = 8'd6;
    localparam logic [7:0]  ProtoUdp      = 8'd17;

    // Well-known ports that mark priority traffic, and the ephemeral floor.
    localparam logic [15:0] PortSsh       = 16'd22;
    localparam logic [15:0] PortDns       = 16'd53;
    localparam logic [15:0] PortHttp      = 16'd80;
    localparam logic [15:0] PortHttps     = 16'd443;
    localparam logic [15:0] PortEphemeral = 16'd49152;

    // Verdict codes.
    localparam logic [1:0] VerdictReject     = 2'd0;
    localparam logic [1:0] VerdictNormal     = 2'd1;
    localparam logic [1:0] VerdictSuspicious = 2'd2;
    localparam logic [1:0] VerdictPriority   = 2'd3;

    // Depth of the queue between parser and record builder.
    localparam int QueueDepth = 2;

    // Everything the parser learned about one frame.
    typedef struct packed {
        logic            reject;
        logic [LenW-1:0] frame_len;
        logic [3:0]      ihl;
        logic [7:0]      proto;
        logic [7:0]      ttl;
        logic [31:0]     src_addr;
        logic [31:0]     dst_addr;
        logic [15:0]     l4_sport;
        logic [15:0]     l4_dport;
        logic [7:0]      flag_byte;
        logic [15:0]     tcp_window;
        logic [3:0]      tcp_offset;
    } t_summary;

    // One feature record; the last member sits in the lowest bits.
    typedef struct packed {
        logic               outbound;
        logic [63:0]        flow_key;
        logic [PayW-1:0]    payload_length;
        logic [15:0]        receive_window;
        logic [7:0]         flag_bits;
        logic [7:0]         hop_limit;
        logic [7:0]         ip_protocol;
        logic [15:0]        dest_port;
        logic [15:0]        source_port;
        logic [31:0]        dest_address;
        logic [31:0]        source_address;
        logic [1:0]         verdict;
    } t_record;

    function automatic logic is_priority_port(input logic [15:0] port);
        is_priority_port = (port == PortSsh) || (port == PortDns) ||
                           (port == PortHttp) || (port == PortHttps);
    endfunction

endpackage

/* rtl/ipv4ffe_parse.sv */
// Front end: captures header bytes of a frame and emits a frame summary on the last byte.
module ipv4ffe_parse (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [7:0]            i_byte,
    input  logic                  i_last,
    input  logic                  i_full,
    output logic                  o_ready,
    output logic                  o_push,
    output ipv4ffe_pkg::t_summary o_summary
);

    localparam int LenW = ipv4ffe_pkg::LenW;

    logic [LenW-1:0] r_pos, n_pos;
    logic [15:0]     r_ether, n_ether;
    logic [3:0]      r_ihl, n_ihl;
    logic [7:0]      r_proto, n_proto;
    logic [7:0]      r_ttl, n_ttl;
    logic [31:0]     r_src, n_src;
    logic [31:0]     r_dst, n_dst;
    logic [15:0]     r_sport, n_sport;
    logic [15:0]     r_dport, n_dport;
    logic [7:0]      r_flags, n_flags;
    logic [15:0]     r_win, n_win;
    logic [3:0]      r_off, n_off;

    logic            accept;
    logic            capture;
    logic [LenW-1:0] tpos;
    logic [LenW-1:0] rel;
    logic [LenW-1:0] frame_len;

    // A byte is taken whenever the queue has room for a possible summary.
    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign capture = r_pos < LenW'(ipv4ffe_pkg::MaxFrameBytes);

    // Field capture for the byte at the current position.
    always_comb begin
        n_ether = r_ether;
        n_ihl   = r_ihl;
        n_proto = r_proto;
        n_ttl   = r_ttl;
        n_src   = r_src;
        n_dst   = r_dst;
        n_sport = r_sport;
        n_dport = r_dport;
        n_flags = r_flags;
        n_win   = r_win;
        n_off   = r_off;
        tpos    = '0;
        rel     = '0;
        if (capture) begin
            if (r_pos == LenW'(12)) n_ether = {i_byte, 8'h00};
            if (r_pos == LenW'(13)) n_ether = {r_ether[15:8], i_byte};
            if (r_pos == LenW'(14)) n_ihl = i_byte[3:0];
            if (r_pos == LenW'(22)) n_ttl = i_byte;
            if (r_pos == LenW'(23)) n_proto = i_byte;
            if (r_pos >= LenW'(26) && r_pos <= LenW'(29)) n_src = {r_src[23:0], i_byte};
            if (r_pos >= LenW'(30) && r_pos <= LenW'(33)) n_dst = {r_dst[23:0], i_byte};
            // Transport bytes follow the IP header as its length field says.
            tpos = LenW'(14) + LenW'({n_ihl, 2'b00});
            if (r_pos >= tpos) begin
                rel = r_pos - tpos;
                if (rel <= LenW'(1)) begin
                    n_sport = {r_sport[7:0], i_byte};
                end else if (rel <= LenW'(3)) begin
                    n_dport = {r_dport[7:0], i_byte};
                end else if (rel == LenW'(12)) begin
                    n_off = i_byte[7:4];
                end else if (rel == LenW'(13)) begin
                    n_flags = i_byte;
                end else if (rel == LenW'(14) || rel == LenW'(15)) begin
                    n_win = {r_win[7:0], i_byte};
                end
            end
        end
    end

    assign frame_len = capture ? r_pos + LenW'(1) : r_pos;
    assign n_pos     = frame_len;

    // Summary of the frame as it stands after this byte.
    always_comb begin
        o_summary.reject     = (frame_len < LenW'(ipv4ffe_pkg::MinFrameBytes)) ||
                               (n_ether != ipv4ffe_pkg::EtherTypeIpv4);
        o_summary.frame_len  = frame_len;
        o_summary.ihl        = n_ihl;
        o_summary.proto      = n_proto;
        o_summary.ttl        = n_ttl;
        o_summary.src_addr   = n_src;
        o_summary.dst_addr   = n_dst;
        o_summary.l4_sport   = n_sport;
        o_summary.l4_dport   = n_dport;
        o_summary.flag_byte  = n_flags;
        o_summary.tcp_window = n_win;
        o_summary.tcp_offset = n_off;
    end

    assign o_push = accept && i_last;

    // Capture registers; all cleared at reset and after every last byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_pos   <= '0;
            r_ether <= '0;
            r_ihl   <= '0;
            r_proto <= '0;
            r_ttl   <= '0;
            r_src   <= '0;
            r_dst   <= '0;
            r_sport <= '0;
            r_dport <= '0;
            r_flags <= '0;
            r_win   <= '0;
            r_off   <= '0;
        end else if (accept) begin
            r_pos   <= n_pos;
            r_ether <= n_ether;
            r_ihl   <= n_ihl;
            r_proto <= n_proto;
            r_ttl   <= n_ttl;
            r_src   <= n_src;
            r_dst   <= n_dst;
            r_sport <= n_sport;
            r_dport <= n_dport;
            r_flags <= n_flags;
            r_win   <= n_win;
            r_off   <= n_off;
        end
    end

    // A last byte always starts the next frame at position zero.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_pos == '0) && (r_ether == '0))
        else $error("parser state not cleared after last byte");

    // The position never runs past the frame limit.
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= LenW'(ipv4ffe_pkg::MaxFrameBytes))
        else $error("byte position beyond frame limit");

endmodule

/* rtl/ipv4ffe_queue.sv */
// Small queue of frame summaries between the parser and the record builder.
module ipv4ffe_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  ipv4ffe_pkg::t_summary i_data,
    input  logic                  i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output ipv4ffe_pkg::t_summary o_data
);

    localparam int Depth = ipv4ffe_pkg::QueueDepth;
    localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW  = $clog2(Depth + 1);

    ipv4ffe_pkg::t_summary r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            do_push, do_pop;

    assign o_full  = r_count == CntW'(Depth);
    assign o_empty = r_count == '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : r_wr_ptr + PtrW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : r_rd_ptr + PtrW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CntW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CntW'(1);
            end
        end
    end

    // The parser must never offer a summary when there is no room for it.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("summary pushed into full queue");

    // A lone push raises the fill count by one.
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> r_count == $past(r_count) + CntW'(1))
        else $error("queue count did not follow a push");

endmodule

/* rtl/ipv4ffe_record.sv */
// Back end: turns a frame summary into a feature record held in the output register.
module ipv4ffe_record (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    input  ipv4ffe_pkg::t_summary i_summary,
    input  logic                  i_ready,
    output logic                  o_pop,
    output logic                  o_valid,
    output ipv4ffe_pkg::t_record  o_record
);

    localparam int W = ipv4ffe_pkg::LenW + 1;

    logic                 r_valid;
    ipv4ffe_pkg::t_record r_record, n_record;

    logic [W-1:0] len_w, t_w, hdr, pay;
    logic         is_tcp, is_udp, tcp_full, tcp_off_seen, udp_full, ports_ok;
    logic [15:0]  sp, dp;
    logic [7:0]   fl;
    logic [15:0]  win;
    logic [1:0]   verdict;

    // Transport header bounds and payload length.
    always_comb begin
        len_w        = W'(i_summary.frame_len);
        t_w          = W'(14) + W'({i_summary.ihl, 2'b00});
        is_tcp       = i_summary.proto == ipv4ffe_pkg::ProtoTcp;
        is_udp       = i_summary.proto == ipv4ffe_pkg::ProtoUdp;
        tcp_full     = (t_w + W'(20)) <= len_w;
        tcp_off_seen = (t_w + W'(13)) <= len_w;
        udp_full     = (t_w + W'(8)) <= len_w;
        ports_ok     = (is_tcp && tcp_full) || (is_udp && udp_full);
        sp           = ports_ok ? i_summary.l4_sport : 16'd0;
        dp           = ports_ok ? i_summary.l4_dport : 16'd0;
        fl           = (is_tcp && tcp_full) ? i_summary.flag_byte : 8'd0;
        win          = (is_tcp && tcp_full) ? i_summary.tcp_window : 16'd0;
        hdr          = t_w;
        if (is_tcp && tcp_off_seen) begin
            hdr = t_w + W'({i_summary.tcp_offset, 2'b00});
        end else if (is_udp) begin
            hdr = t_w + W'(8);
        end
        pay = (hdr < len_w) ? len_w - hdr : '0;
    end

    // Traffic class from the ports and the protocol.
    always_comb begin
        if (ipv4ffe_pkg::is_priority_port(sp) || ipv4ffe_pkg::is_priority_port(dp)) begin
            verdict = ipv4ffe_pkg::VerdictPriority;
        end else if ((sp > ipv4ffe_pkg::PortEphemeral && dp > ipv4ffe_pkg::PortEphemeral) ||
                     (!is_tcp && !is_udp)) begin
            verdict = ipv4ffe_pkg::VerdictSuspicious;
        end else begin
            verdict = ipv4ffe_pkg::VerdictNormal;
        end
    end

    // Record assembly; a rejected frame gives an all-zero record.
    always_comb begin
        n_record = '0;
        if (!i_summary.reject) begin
            n_record.verdict        = verdict;
            n_record.source_address = i_summary.src_addr;
            n_record.dest_address   = i_summary.dst_addr;
            n_record.source_port    = sp;
            n_record.dest_port      = dp;
            n_record.ip_protocol    = i_summary.proto;
            n_record.hop_limit      = i_summary.ttl;
            n_record.flag_bits      = fl;
            n_record.receive_window = win;
            n_record.payload_length = ipv4ffe_pkg::PayW'(pay);
            n_record.flow_key       = {32'd0, i_summary.src_addr} ^
                                      {i_summary.dst_addr, 32'd0} ^
                                      {32'd0, sp, 16'd0} ^
                                      {dp, 48'd0} ^
                                      {48'd0, i_summary.proto, 8'd0};
            n_record.outbound       = sp > dp;
        end
    end

    // The output register reloads whenever the queue holds a summary and the register is empty or being drained.
    assign o_pop = !i_empty && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_record <= n_record;
        end
    end

    assign o_valid  = r_valid;
    assign o_record = r_record;

    // A rejected record carries nothing but its verdict of zero.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_record.verdict == ipv4ffe_pkg::VerdictReject) |->
            (r_record.flow_key == '0) && (r_record.source_port == '0) &&
            (r_record.payload_length == '0))
        else $error("rejected record has nonzero fields");

    // A popped summary always lands in the output register.
    a_pop_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_valid)
        else $error("output register not loaded after pop");

endmodule

/* rtl/ipv4_flow_feature_extractor_core.sv */
// Top level of the IPv4 flow feature extractor: parser, summary queue and record builder.
//
//  Channel   Direction  Ports                    Contents
//  s_axis    in         tvalid tready tdata      frame bytes, tlast on the final byte
//  m_axis    out        tvalid tready tdata      one feature record per frame
//
// One frame byte is taken every cycle; s_axis_tready drops only while the
// two-entry summary queue is full. A record reaches m_axis by way of the queue:
// the last byte's summary is written into the queue, then loads the record
// builder's output register once that register is empty or being drained.
// Reset clears the capture state, the queue pointers and the output valid flag.
// A stalled m_axis side holds the record; bytes keep flowing until the queue fills.
module ipv4_flow_feature_extractor_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tlast,   // last_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [215:0] m_axis_tdata    // verdict[1:0], source_address[33:2],
                                         // dest_address[65:34], source_port[81:66],
                                         // dest_port[97:82], ip_protocol[105:98],
                                         // hop_limit[113:106], flag_bits[121:114],
                                         // receive_window[137:122],
                                         // payload_length[150:138], flow_key[214:151],
                                         // outbound[215]
);

    ipv4ffe_pkg::t_summary push_data, head_data;
    ipv4ffe_pkg::t_record  record;
    logic push, pop, full, empty;

    // Byte parser.
    ipv4ffe_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .i_byte    (s_axis_tdata),
        .i_last    (s_axis_tlast),
        .i_full    (full),
        .o_ready   (s_axis_tready),
        .o_push    (push),
        .o_summary (push_data)
    );

    // Summary queue.
    ipv4ffe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_data  (head_data)
    );

    // Record builder.
    ipv4ffe_record u_record (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (empty),
        .i_summary (head_data),
        .i_ready   (m_axis_tready),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .o_record  (record)
    );

    assign m_axis_tdata = record;

endmodule
